// ===== rtl/core/ipv4dq_pkg.sv =====
// Package for the IPv4 dotted-quad parser: item codes, character constants
// and queue sizing shared by the front, queue and back modules.
// No dependencies.
package ipv4dq_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [3:0]  RADIX      = 4'd10;
  localparam logic [11:0] OCTET_MAX  = 12'd255;
  localparam logic [1:0]  MAX_DIGITS = 2'd3;
  localparam logic [1:0]  LAST_OCTET = 2'd3;
  localparam logic [31:0] ADDR_NONE  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_DOT,
    OP_BAD,
    OP_END
  } item_op_e;

  typedef struct packed {
    item_op_e   op;
    logic [3:0] digit;
  } item_t;

endpackage

// ===== rtl/core/ipv4dq_front.sv =====
// Front end of the IPv4 dotted-quad parser: classifies each incoming character.
// Depends on ipv4dq_pkg.
module ipv4dq_front import ipv4dq_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // character [7:0]
  input  logic       s_axis_tlast,
  input  logic       push_ready_i,
  output logic       push_valid_o,
  output item_t      push_item_o
);

  logic       is_digit;
  logic [7:0] digit_full;

  assign is_digit      = (s_axis_tdata >= CHAR_ZERO) && (s_axis_tdata <= CHAR_NINE);
  assign digit_full    = s_axis_tdata - CHAR_ZERO;
  assign s_axis_tready = push_ready_i;
  assign push_valid_o  = s_axis_tvalid;

  always_comb begin
    push_item_o.digit = digit_full[3:0];
    if (s_axis_tlast) begin
      push_item_o.op = OP_END;
    end else if (is_digit) begin
      push_item_o.op = OP_DIGIT;
    end else if (s_axis_tdata == CHAR_DOT) begin
      push_item_o.op = OP_DOT;
    end else begin
      push_item_o.op = OP_BAD;
    end
  end

endmodule

// ===== rtl/core/ipv4dq_fifo.sv =====
// Short queue of classified items between the front and back of the parser.
// Depends on ipv4dq_pkg.
module ipv4dq_fifo import ipv4dq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/ipv4dq_back.sv =====
// Back end of the IPv4 dotted-quad parser: octet accumulation, error tracking
// and the registered result stage. Depends on ipv4dq_pkg.
module ipv4dq_back import ipv4dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  item_t       pop_item_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // address [31:0]
  output logic        m_axis_tuser   // valid_res [0]
);

  logic [1:0]  octet_index_q, octet_index_d;
  logic [1:0]  digit_count_q, digit_count_d;
  logic [7:0]  octet_value_q, octet_value_d;
  logic [7:0]  finished_q [3];
  logic        error_q, error_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q;
  logic        out_ok_q;
  logic        do_pop, is_end, result_ok;
  logic [11:0] next_value;

  assign is_end      = (pop_item_i.op == OP_END);
  assign pop_ready_o = !is_end || !out_valid_q || m_axis_tready;
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign next_value  = 12'(octet_value_q) * 12'(RADIX) + 12'(pop_item_i.digit);
  assign result_ok   = !error_q && (octet_index_q == LAST_OCTET) && (digit_count_q != '0);

  always_comb begin
    octet_index_d = octet_index_q;
    digit_count_d = digit_count_q;
    octet_value_d = octet_value_q;
    error_d       = error_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    if (do_pop) begin
      if (is_end) begin
        octet_index_d = '0;
        digit_count_d = '0;
        octet_value_d = '0;
        error_d       = 1'b0;
        out_valid_d   = 1'b1;
      end else if (!error_q) begin
        case (pop_item_i.op)
          OP_DIGIT: begin
            if (digit_count_q == MAX_DIGITS || next_value > OCTET_MAX) begin
              error_d = 1'b1;
            end else begin
              octet_value_d = next_value[7:0];
              digit_count_d = digit_count_q + 1'b1;
            end
          end
          OP_DOT: begin
            if (digit_count_q == '0 || octet_index_q == LAST_OCTET) begin
              error_d = 1'b1;
            end else begin
              octet_index_d = octet_index_q + 1'b1;
              digit_count_d = '0;
              octet_value_d = '0;
            end
          end
          default: begin
            error_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octet_index_q <= '0;
      digit_count_q <= '0;
      octet_value_q <= '0;
      error_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      finished_q[0] <= '0;
      finished_q[1] <= '0;
      finished_q[2] <= '0;
    end else begin
      octet_index_q <= octet_index_d;
      digit_count_q <= digit_count_d;
      octet_value_q <= octet_value_d;
      error_q       <= error_d;
      out_valid_q   <= out_valid_d;
      if (do_pop && !error_q && pop_item_i.op == OP_DOT && digit_count_q != '0 &&
          octet_index_q != LAST_OCTET) begin
        finished_q[octet_index_q] <= octet_value_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop && is_end) begin
      out_ok_q   <= result_ok;
      out_addr_q <= result_ok ? {octet_value_q, finished_q[2], finished_q[1], finished_q[0]}
                              : ADDR_NONE;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_ok_q;

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (error_q && !(do_pop && is_end)) |=> error_q)
    else $error("error flag dropped inside a string");

  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && is_end) |=> (octet_index_q == '0 && digit_count_q == '0 && !error_q))
    else $error("parser state not cleared after end of string");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && is_end) |=> out_valid_q)
    else $error("end of string produced no result");

  a_invalid_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_addr_q == ADDR_NONE))
    else $error("invalid result without all-ones address");

endmodule

// ===== rtl/core/ipv4_dotted_quad_parser.sv =====
// Top level of the IPv4 dotted-quad parser: front classifier, item queue and
// back-end accumulator. Depends on ipv4dq_pkg, ipv4dq_front, ipv4dq_fifo, ipv4dq_back.
//
//   Channel   Dir  tdata              tuser           tlast
//   s_axis    in   character [7:0]    -               end_of_string
//   m_axis    out  address [31:0]     valid_res [0]   -
//
// One character transfer is taken per cycle while the queue has room; the end-of-string
// item passes the queue, then the output register, and there is one result per string.
// The back end updates its state once per item, with a two-entry queue between classifier
// and accumulator. Reset clears control state at once, not queue or result data; no sweep.
// Input stalls only when the queue is full, which needs an output stall on a result.
module ipv4_dotted_quad_parser import ipv4dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // character [7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // address [31:0]
  output logic        m_axis_tuser    // valid_res [0]
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  ipv4dq_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push_ready_i  (push_ready),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item)
  );

  ipv4dq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ipv4dq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for ipv4_dotted_quad_parser: dotted-decimal strings go in one
// character per transfer, and each parse result is compared with a local predictor.
// Depends on ipv4dq_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;
  import ipv4dq_pkg::*;

  typedef struct {
    logic [31:0] address;
    logic        valid_res;
  } parse_result_t;

  typedef enum int {
    STR_GOOD,
    STR_SHORT,
    STR_EXTRA_DOT,
    STR_FOUR_DIGITS,
    STR_OVER_MAX,
    STR_BAD_BYTE,
    STR_DOUBLE_DOT,
    STR_EMPTY_LAST,
    STR_NOISE
  } string_kind_e;

  class addr_scoreboard;
    logic [1:0]    octet_idx;
    logic [1:0]    digit_cnt;
    logic [7:0]    cur_octet;
    logic [7:0]    done_octets [3];
    bit            err_flag;
    parse_result_t expected_q [$];
    int            errors;
    int            n_valid;
    int            n_invalid;

    function new();
      clear_parse();
      errors    = 0;
      n_valid   = 0;
      n_invalid = 0;
    endfunction

    function void clear_parse();
      octet_idx = '0;
      digit_cnt = '0;
      cur_octet = '0;
      foreach (done_octets[i]) done_octets[i] = '0;
      err_flag = 1'b0;
    endfunction

    function void note_transfer(logic [7:0] c, logic eos);
      parse_result_t r;
      int            v;
      if (eos) begin
        r.valid_res = !err_flag && octet_idx == LAST_OCTET && digit_cnt != 2'd0;
        r.address   = r.valid_res ? {cur_octet, done_octets[2], done_octets[1], done_octets[0]}
                                  : ADDR_NONE;
        expected_q.push_back(r);
        clear_parse();
      end else if (!err_flag) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          v = int'(cur_octet) * int'(RADIX) + int'(c - CHAR_ZERO);
          if (digit_cnt >= MAX_DIGITS || v > int'(OCTET_MAX)) begin
            err_flag = 1'b1;
          end else begin
            cur_octet = v[7:0];
            digit_cnt = digit_cnt + 2'd1;
          end
        end else if (c == CHAR_DOT) begin
          if (digit_cnt == 2'd0 || octet_idx >= LAST_OCTET) begin
            err_flag = 1'b1;
          end else begin
            done_octets[octet_idx] = cur_octet;
            octet_idx = octet_idx + 2'd1;
            digit_cnt = '0;
            cur_octet = '0;
          end
        end else begin
          err_flag = 1'b1;
        end
      end
    endfunction

    function void check_result(logic [31:0] addr, logic ok);
      parse_result_t r;
      if (expected_q.size() == 0) begin
        $error("Result with no parse pending: address %h valid_res %b", addr, ok);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (r.valid_res) n_valid++;
      else n_invalid++;
      if (addr !== r.address) begin
        $error("address: expected %h, actual %h", r.address, addr);
        errors++;
      end
      if (ok !== r.valid_res) begin
        $error("valid_res: expected %b, actual %b", r.valid_res, ok);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  addr_scoreboard sb;
  logic [7:0]     str_q [$];
  int             chars_accepted;
  int             in_stall_cycles;
  int             strings_sent;
  int             burst_left;
  bit             hold_req;

  ipv4_dotted_quad_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // Transfers are observed with the values that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_transfer(s_axis_tdata, s_axis_tlast);
        chars_accepted++;
      end
      if (s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int mode;
    int mode_left;
    int phase;
    m_axis_tready = 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready <= ((phase % 7) < 3);
          end
        endcase
      end
    end
  end

  function automatic void push_num(int v, int ndig);
    int div;
    div = 1;
    repeat (ndig - 1) div *= 10;
    repeat (ndig) begin
      str_q.push_back(8'(int'(CHAR_ZERO) + (v / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic void push_octet();
    int v;
    int sel;
    int need;
    int nd;
    sel = $urandom_range(0, 9);
    if (sel == 0) v = 0;
    else if (sel == 1) v = 255;
    else if (sel < 5) v = $urandom_range(0, 9);
    else v = $urandom_range(0, 255);
    need = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    nd = need;
    if ($urandom_range(0, 3) == 0) nd = $urandom_range(need, 3);
    push_num(v, nd);
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_DOT);
    if ($urandom_range(0, 7) == 0) b = 8'h00;
    return b;
  endfunction

  function automatic string_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return STR_GOOD;
    if (r < 61) return STR_SHORT;
    if (r < 67) return STR_EXTRA_DOT;
    if (r < 73) return STR_FOUR_DIGITS;
    if (r < 79) return STR_OVER_MAX;
    if (r < 85) return STR_BAD_BYTE;
    if (r < 90) return STR_DOUBLE_DOT;
    if (r < 95) return STR_EMPTY_LAST;
    return STR_NOISE;
  endfunction

  function automatic void gen_string();
    string_kind_e kind;
    int           n_oct;
    int           bad_pos;
    int           len;
    kind = pick_kind();
    str_q.delete();
    bad_pos = $urandom_range(0, 3);
    if (kind == STR_NOISE) begin
      len = $urandom_range(0, 20);
      repeat (len) str_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_oct = 4;
    if (kind == STR_SHORT) n_oct = $urandom_range(1, 3);
    if (kind == STR_EMPTY_LAST) n_oct = $urandom_range(0, 1) ? 3 : 0;
    for (int i = 0; i < n_oct; i++) begin
      if (i > 0) begin
        str_q.push_back(CHAR_DOT);
        if (kind == STR_DOUBLE_DOT && i == bad_pos) str_q.push_back(CHAR_DOT);
      end
      if (kind == STR_FOUR_DIGITS && i == bad_pos) push_num($urandom_range(0, 9999), 4);
      else if (kind == STR_OVER_MAX && i == bad_pos) push_num($urandom_range(256, 999), 3);
      else push_octet();
    end
    if (kind == STR_DOUBLE_DOT && bad_pos == 0) str_q.push_front(CHAR_DOT);
    if (kind == STR_EXTRA_DOT) begin
      str_q.push_back(CHAR_DOT);
      if ($urandom_range(0, 1)) push_octet();
    end
    if ((kind == STR_EMPTY_LAST && n_oct == 3) || (kind == STR_SHORT && $urandom_range(0, 1))) begin
      str_q.push_back(CHAR_DOT);
    end
    if (kind == STR_BAD_BYTE) str_q.insert($urandom_range(0, str_q.size()), bad_byte());
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eos);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drive_string();
    foreach (str_q[i]) send_item(str_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic drive_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    drive_string();
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int wait_cycles;
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    chars_accepted  = 0;
    in_stall_cycles = 0;
    strings_sent    = 0;
    burst_left      = 0;
    hold_req        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_text("");
    drive_text("0.0.0.255");
    drive_text("1000");
    drive_text("256");
    drive_text(".");
    str_q = '{8'h00};
    drive_string();
    drive_text("1.2.3.4.");

    while (chars_accepted < 1650) begin
      if (strings_sent % 50 == 20) hold_req = 1'b1;
      if (strings_sent % 50 == 40) wait_results_done();
      gen_string();
      drive_string();
    end

    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("Parsed %0d strings in %0d character transfers: %0d valid, %0d rejected.",
             strings_sent, chars_accepted, sb.n_valid, sb.n_invalid);
    $display("Input was held back for %0d cycles by output back-pressure.", in_stall_cycles);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ipv4dq_pkg.sv
rtl/core/ipv4dq_front.sv
rtl/core/ipv4dq_fifo.sv
rtl/core/ipv4dq_back.sv
rtl/core/ipv4_dotted_quad_parser.sv
test/tb.sv
